### sv/fabt_pkg.sv
package fabt_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 64;

   localparam int ADDR_W  = 32;
   localparam int TIME_W  = 32;
   localparam int COUNT_W = 16;
   localparam int SPAN_W  = 20;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Request kinds carried in the request tuser.
   localparam logic [1:0] MODE_RECORD = 2'd0;
   localparam logic [1:0] MODE_CLEAR  = 2'd1;
   localparam logic [1:0] MODE_CHECK  = 2'd2;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_WINDOW    = 2'd0;
   localparam logic [1:0] CSR_THRESHOLD = 2'd1;
   localparam logic [1:0] CSR_DURATION  = 2'd2;

   localparam logic [SPAN_W-1:0]  WINDOW_RESET    = 20'd60;
   localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 16'd5;
   localparam logic [SPAN_W-1:0]  DURATION_RESET  = 20'd600;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_EXEC
   } fabt_state_type;

   // One table entry as held in the memory.
   typedef struct packed {
      logic [TIME_W-1:0]  last_time;
      logic [COUNT_W-1:0] count;
      logic [ADDR_W-1:0]  address;
   } fabt_entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic read;
      logic exec;
   } fabt_cmd_type;

endpackage

### sv/fabt_ctrl.sv
module fabt_ctrl #(
   parameter int TABLE_ENTRIES = fabt_pkg::TABLE_ENTRIES_DEFAULT,
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output fabt_pkg::fabt_cmd_type cmd,
   output logic [IDX_W-1:0]     scan_idx
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   fabt_pkg::fabt_state_type state_ff, state_in;
   logic [IDX_W-1:0]         scan_ff, scan_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fabt_pkg::ST_IDLE;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      req_tready   = 1'b0;
      case (state_ff)
         fabt_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               scan_in     = '0;
               state_in    = fabt_pkg::ST_SCAN;
            end
         end
         fabt_pkg::ST_SCAN: begin
            cmd.read = 1'b1;
            if (scan_ff == LAST_IDX) begin
               state_in = fabt_pkg::ST_DRAIN;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         fabt_pkg::ST_DRAIN: begin
            state_in = fabt_pkg::ST_EXEC;
         end
         fabt_pkg::ST_EXEC: begin
            // The result register must be free before it is overwritten.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.exec     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = fabt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fabt_pkg::ST_IDLE;
         end
      endcase
   end

   assign scan_idx   = scan_ff;
   assign rsp_tvalid = rsp_valid_ff;

   a_scan_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == fabt_pkg::ST_SCAN && scan_ff == '0)
      else $error("scan did not start at entry zero after an accepted request");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> !rsp_valid_ff || rsp_tready)
      else $error("pending result overwritten");

   a_result_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == fabt_pkg::ST_EXEC)
      else $error("result raised outside the execute step");

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == fabt_pkg::ST_SCAN |-> !req_tready && !cmd.exec)
      else $error("request taken or executed during a scan");

endmodule

### sv/fabt_dp.sv
module fabt_dp #(
   parameter int TABLE_ENTRIES = fabt_pkg::TABLE_ENTRIES_DEFAULT,
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  fabt_pkg::fabt_cmd_type             cmd,
   input  logic [IDX_W-1:0]                   scan_idx,
   input  logic [fabt_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [1:0]                         req_tuser,
   input  logic                               csr_write,
   input  logic [1:0]                         csr_index,
   input  logic [fabt_pkg::SPAN_W-1:0]        csr_wdata,
   output logic [fabt_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int ADDR_W  = fabt_pkg::ADDR_W;
   localparam int TIME_W  = fabt_pkg::TIME_W;
   localparam int COUNT_W = fabt_pkg::COUNT_W;
   localparam int SPAN_W  = fabt_pkg::SPAN_W;

   // Configuration registers.
   logic [SPAN_W-1:0]  window_ff;
   logic [COUNT_W-1:0] threshold_ff;
   logic [SPAN_W-1:0]  duration_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= fabt_pkg::WINDOW_RESET;
         threshold_ff <= fabt_pkg::THRESHOLD_RESET;
         duration_ff  <= fabt_pkg::DURATION_RESET;
      end else if (csr_write) begin
         case (csr_index)
            fabt_pkg::CSR_WINDOW:    window_ff    <= csr_wdata;
            fabt_pkg::CSR_THRESHOLD: threshold_ff <= csr_wdata[COUNT_W-1:0];
            fabt_pkg::CSR_DURATION:  duration_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Request held for the whole scan.
   logic [1:0]        mode_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [TIME_W-1:0] now_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_tuser;
         addr_ff <= req_tdata[ADDR_W-1:0];
         now_ff  <= req_tdata[ADDR_W +: TIME_W];
      end
   end

   // Entry memory, valid bits in flip-flops.
   fabt_pkg::fabt_entry_type mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff;

   fabt_pkg::fabt_entry_type rd_entry_ff;
   logic                     rd_valid_ff;
   logic [IDX_W-1:0]         rd_idx_ff;
   logic                     cmp_pend_ff;

   logic                     wr_en;
   logic [IDX_W-1:0]         wr_idx;
   fabt_pkg::fabt_entry_type wr_entry;
   logic                     set_en, drop_en;
   logic [IDX_W-1:0]         flag_idx;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_entry;
      end
      if (cmd.read) begin
         rd_entry_ff <= mem[scan_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         cmp_pend_ff <= 1'b0;
      end else begin
         cmp_pend_ff <= cmd.read;
         if (set_en) begin
            valid_ff[flag_idx] <= 1'b1;
         end else if (drop_en) begin
            valid_ff[flag_idx] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_valid_ff <= valid_ff[scan_idx];
         rd_idx_ff   <= scan_idx;
      end
   end

   // Search results, one entry compared per cycle.
   logic               hit_ff, free_ff;
   logic [IDX_W-1:0]   hit_idx_ff, free_idx_ff;
   logic [COUNT_W-1:0] hit_count_ff;
   logic [TIME_W-1:0]  hit_time_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.capture) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else if (cmp_pend_ff) begin
         if (rd_valid_ff && rd_entry_ff.address == addr_ff) begin
            hit_ff <= 1'b1;
         end
         if (!rd_valid_ff && !free_ff) begin
            free_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmp_pend_ff && rd_valid_ff && rd_entry_ff.address == addr_ff) begin
         hit_idx_ff   <= rd_idx_ff;
         hit_count_ff <= rd_entry_ff.count;
         hit_time_ff  <= rd_entry_ff.last_time;
      end
      if (cmp_pend_ff && !rd_valid_ff && !free_ff) begin
         free_idx_ff <= rd_idx_ff;
      end
   end

   // Update step: one 33-bit add and compare shared by record and check.
   logic [SPAN_W-1:0]  span;
   logic [TIME_W:0]    limit;
   logic               late;
   logic [COUNT_W-1:0] next_count;
   logic [COUNT_W-1:0] count_res;
   logic               black_res, full_res;
   logic [fabt_pkg::RSP_DATA_W-1:0] rsp_ff, rsp_in;

   always_comb begin
      span       = (mode_ff == fabt_pkg::MODE_CHECK) ? duration_ff : window_ff;
      limit      = {1'b0, hit_time_ff} + (TIME_W + 1)'(span);
      late       = limit < {1'b0, now_ff};
      next_count = late ? COUNT_W'(1) :
                   (hit_count_ff == fabt_pkg::COUNT_MAX) ? hit_count_ff :
                   hit_count_ff + 1'b1;
      wr_en      = 1'b0;
      wr_idx     = hit_idx_ff;
      wr_entry   = '{last_time: now_ff, count: next_count, address: addr_ff};
      set_en     = 1'b0;
      drop_en    = 1'b0;
      flag_idx   = hit_idx_ff;
      count_res  = '0;
      black_res  = 1'b0;
      full_res   = 1'b0;
      case (mode_ff)
         fabt_pkg::MODE_RECORD: begin
            if (hit_ff) begin
               wr_en     = cmd.exec;
               count_res = next_count;
            end else if (free_ff) begin
               wr_en          = cmd.exec;
               wr_idx         = free_idx_ff;
               wr_entry.count = COUNT_W'(1);
               set_en         = cmd.exec;
               flag_idx       = free_idx_ff;
               count_res      = COUNT_W'(1);
            end else begin
               full_res = 1'b1;
            end
         end
         fabt_pkg::MODE_CLEAR: begin
            drop_en = cmd.exec && hit_ff;
         end
         fabt_pkg::MODE_CHECK: begin
            if (hit_ff && hit_count_ff >= threshold_ff) begin
               if (late) begin
                  drop_en = cmd.exec;
               end else begin
                  black_res = 1'b1;
               end
            end
         end
         default: ;
      endcase
      rsp_in = {{(fabt_pkg::RSP_DATA_W - COUNT_W - 2){1'b0}}, full_res, black_res, count_res};
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tdata = rsp_ff;

endmodule

### sv/failed_attempt_blacklist_table_unit.sv
// Channel   Direction  Handshake               Payload
// req_      in         req_tvalid/req_tready   tdata: address, time; tuser: mode
// rsp_      out        rsp_tvalid/rsp_tready   tdata: count, blacklisted, full
// csr_      in         csr_valid/csr_ready     csr_index, csr_wdata
//
// Every request scans the whole table, one entry a cycle through the single
// read port of the entry memory. Its result beat is registered after the scan,
// a drain step and an update step, and the next request is taken once the
// controller is back in its idle state.
// Reset is synchronous and empties the table at once through the valid flops.
// A result left waiting lets the next request scan but holds it at its update.
module failed_attempt_blacklist_table_unit #(
   parameter int TABLE_ENTRIES = fabt_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request beat.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [31:0] ipv4_address, [63:32] now_seconds
   input  logic [fabt_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] mode
   input  logic [1:0]                      req_tuser,
   // Result beat.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [15:0] failure_count, [16] blacklisted, [17] table_full, [23:18] zero
   output logic [fabt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // Configuration writes.
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [1:0]                      csr_index,
   input  logic [fabt_pkg::SPAN_W-1:0]     csr_wdata
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   fabt_pkg::fabt_cmd_type cmd;
   logic [IDX_W-1:0]       scan_idx;

   // Registers are simple flops, so a write can be taken in any cycle.
   assign csr_ready = 1'b1;

   // The controller sequences accept, scan, drain and update; the datapath
   // holds the table, the search results and the result register.
   fabt_ctrl #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .cmd       (cmd),
      .scan_idx  (scan_idx)
   );

   fabt_dp #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .scan_idx  (scan_idx),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

### test/tb_failed_attempt_blacklist_table_unit.sv
`timescale 1ns / 1ps

module tb_failed_attempt_blacklist_table_unit;

   // The block answers every request with exactly one result beat, so the
   // bench keeps a single in-order queue of expected verdicts.
   localparam int TABLE_ENTRIES = fabt_pkg::TABLE_ENTRIES_DEFAULT;

   localparam int ADDR_W     = fabt_pkg::ADDR_W;
   localparam int TIME_W     = fabt_pkg::TIME_W;
   localparam int COUNT_W    = fabt_pkg::COUNT_W;
   localparam int SPAN_W     = fabt_pkg::SPAN_W;
   localparam int REQ_DATA_W = fabt_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W = fabt_pkg::RSP_DATA_W;

   // The request kind and register index that the block must ignore.
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [1:0] CSR_NONE    = 2'd3;

   localparam int POOL_N           = 80;
   localparam int PHASES           = 5;
   localparam int RANDOM_PER_PHASE = 176;
   localparam int FLOOD_ITEMS      = 70;
   localparam int DIRECTED_N       = 22;
   localparam int MAX_REPORTS      = 10;
   // The tail wait outlasts one whole request with its scan of the table.
   localparam int DRAIN_CYCLES     = TABLE_ENTRIES + 16;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               blacklisted;
      logic               table_full;
   } attempt_verdict_type;

   typedef struct packed {
      logic [1:0]          mode;
      logic [ADDR_W-1:0]   addr;
      logic [TIME_W-1:0]   now_s;
      logic                typed;
      attempt_verdict_type verdict;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [1:0]            req_tuser  = fabt_pkg::MODE_RECORD;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [1:0]            csr_index  = fabt_pkg::CSR_WINDOW;
   logic [SPAN_W-1:0]     csr_wdata  = '0;

   // The bench's own copy of the blacklist table and of its registers.
   logic                  ban_valid [TABLE_ENTRIES];
   logic [ADDR_W-1:0]     ban_addr  [TABLE_ENTRIES];
   logic [COUNT_W-1:0]    ban_count [TABLE_ENTRIES];
   logic [TIME_W-1:0]     ban_last  [TABLE_ENTRIES];
   logic [SPAN_W-1:0]     cur_window    = fabt_pkg::WINDOW_RESET;
   logic [COUNT_W-1:0]    cur_threshold = fabt_pkg::THRESHOLD_RESET;
   logic [SPAN_W-1:0]     cur_duration  = fabt_pkg::DURATION_RESET;

   attempt_verdict_type pending_verdicts [$];
   int verdict_errors = 0;
   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;

   // Directed rows run from reset with the reset register values. A row whose
   // typed flag is set carries its verdict written out by hand; the others
   // take the verdict that the predictor works out.
   directed_row_type directed_rows [DIRECTED_N] = '{
      '{fabt_pkg::MODE_CHECK,  32'h0000_0000, 32'd0,         1'b1, '{16'd0, 1'b0, 1'b0}},
      '{fabt_pkg::MODE_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{16'd0, 1'b0, 1'b0}},
      '{MODE_UNUSED,           32'h1234_5678, 32'd100,       1'b1, '{16'd0, 1'b0, 1'b0}},
      '{fabt_pkg::MODE_RECORD, 32'h0000_0000, 32'd0,         1'b1, '{16'd1, 1'b0, 1'b0}},
      '{fabt_pkg::MODE_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{16'd1, 1'b0, 1'b0}},
      '{fabt_pkg::MODE_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{16'd2, 1'b0, 1'b0}},
      '{fabt_pkg::MODE_CHECK,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{16'd0, 1'b0, 1'b0}},
      '{MODE_UNUSED,           32'hFFFF_FFFF, 32'd0,         1'b1, '{16'd0, 1'b0, 1'b0}},
      '{fabt_pkg::MODE_RECORD, 32'hFFFF_FFFF, 32'd0,         1'b0, '0},
      '{fabt_pkg::MODE_RECORD, 32'h0000_0000, 32'd10,        1'b0, '0},
      '{fabt_pkg::MODE_RECORD, 32'h0000_0000, 32'd20,        1'b0, '0},
      '{fabt_pkg::MODE_RECORD, 32'h0000_0000, 32'd30,        1'b0, '0},
      '{fabt_pkg::MODE_CHECK,  32'h0000_0000, 32'd30,        1'b1, '{16'd0, 1'b0, 1'b0}},
      '{fabt_pkg::MODE_RECORD, 32'h0000_0000, 32'd90,        1'b0, '0},
      '{fabt_pkg::MODE_CHECK,  32'h0000_0000, 32'd690,       1'b1, '{16'd0, 1'b1, 1'b0}},
      '{fabt_pkg::MODE_CHECK,  32'h0000_0000, 32'd5,         1'b0, '0},
      '{fabt_pkg::MODE_RECORD, 32'h0000_0000, 32'd20,        1'b0, '0},
      '{fabt_pkg::MODE_CHECK,  32'h0000_0000, 32'd621,       1'b1, '{16'd0, 1'b0, 1'b0}},
      '{fabt_pkg::MODE_RECORD, 32'h0000_0000, 32'd622,       1'b0, '0},
      '{fabt_pkg::MODE_RECORD, 32'h0000_0000, 32'd683,       1'b0, '0},
      '{fabt_pkg::MODE_CLEAR,  32'h0000_0000, 32'd683,       1'b1, '{16'd0, 1'b0, 1'b0}},
      '{fabt_pkg::MODE_CHECK,  32'h0000_0000, 32'd683,       1'b1, '{16'd0, 1'b0, 1'b0}}
   };

   failed_attempt_blacklist_table_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // A generous ceiling: a correct run needs well under a tenth of this.
   initial begin
      #2000000;
      $display("tb_failed_attempt_blacklist_table_unit NOT OK");
      $finish;
   end

   // Applies one request to the bench's table and returns the verdict the
   // block must give. A known address is always found before a free slot is
   // taken, and time sums are formed one bit wider so that they never wrap.
   function automatic attempt_verdict_type tally_attempt(input logic [1:0] mode,
                                                         input logic [ADDR_W-1:0] addr,
                                                         input logic [TIME_W-1:0] now_s);
      attempt_verdict_type v;
      int hit;
      int slot;
      logic [TIME_W:0] now_w;
      v     = '0;
      hit   = -1;
      slot  = -1;
      now_w = {1'b0, now_s};
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (hit < 0 && ban_valid[i] && ban_addr[i] == addr) hit = i;
         if (slot < 0 && !ban_valid[i]) slot = i;
      end
      case (mode)
         fabt_pkg::MODE_RECORD: begin
            if (hit >= 0) begin
               if ({1'b0, ban_last[hit]} + {13'd0, cur_window} < now_w) begin
                  ban_count[hit] = 16'd1;
               end else if (ban_count[hit] != fabt_pkg::COUNT_MAX) begin
                  ban_count[hit] = ban_count[hit] + 16'd1;
               end
               ban_last[hit] = now_s;
               v.count       = ban_count[hit];
            end else if (slot >= 0) begin
               ban_valid[slot] = 1'b1;
               ban_addr[slot]  = addr;
               ban_count[slot] = 16'd1;
               ban_last[slot]  = now_s;
               v.count         = 16'd1;
            end else begin
               v.table_full = 1'b1;
            end
         end
         fabt_pkg::MODE_CLEAR: begin
            if (hit >= 0) ban_valid[hit] = 1'b0;
         end
         fabt_pkg::MODE_CHECK: begin
            if (hit >= 0 && ban_count[hit] >= cur_threshold) begin
               if ({1'b0, ban_last[hit]} + {13'd0, cur_duration} >= now_w) begin
                  v.blacklisted = 1'b1;
               end else begin
                  ban_valid[hit] = 1'b0;
               end
            end
         end
         default: ;
      endcase
      return v;
   endfunction

   // Offers one request beat, with a random gap in front of it, and files its
   // verdict once the beat has been taken. Handshakes are sampled at the
   // falling edge, where every signal has settled, and acted on at the next
   // rising edge. Valid is left high on return so that a following beat can
   // go out back to back; callers lower it before any other kind of wait.
   task automatic send_request(input logic [1:0] mode,
                               input logic [ADDR_W-1:0] addr,
                               input logic [TIME_W-1:0] now_s,
                               input logic typed,
                               input attempt_verdict_type typed_verdict);
      logic taken;
      attempt_verdict_type v;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {now_s, addr};
      req_tuser  <= mode;
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      v = tally_attempt(mode, addr, now_s);
      pending_verdicts.push_back(typed ? typed_verdict : v);
   endtask

   // Writes one register. Valid stays high for a following write; the caller
   // lowers it after the last one.
   task automatic write_register(input logic [1:0] index, input logic [SPAN_W-1:0] value);
      logic taken;
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      case (index)
         fabt_pkg::CSR_WINDOW:    cur_window    = value;
         fabt_pkg::CSR_THRESHOLD: cur_threshold = value[COUNT_W-1:0];
         fabt_pkg::CSR_DURATION:  cur_duration  = value;
         default: ;
      endcase
   endtask

   // The receiver withholds ready at random, one decision per cycle.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Each result beat is checked against the oldest verdict still waiting.
   always @(negedge clock) begin : verdict_check
      attempt_verdict_type seen;
      attempt_verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.count       = rsp_tdata[15:0];
         seen.blacklisted = rsp_tdata[16];
         seen.table_full  = rsp_tdata[17];
         if (pending_verdicts.size() == 0) begin
            if (verdict_errors < MAX_REPORTS) begin
               $display("result beat with nothing expected: count %0d blacklisted %0d full %0d",
                        seen.count, seen.blacklisted, seen.table_full);
            end
            verdict_errors++;
         end else begin
            want = pending_verdicts.pop_front();
            if (seen.count != want.count || seen.blacklisted != want.blacklisted ||
                seen.table_full != want.table_full) begin
               if (verdict_errors < MAX_REPORTS) begin
                  $display("result mismatch: expected count %0d blacklisted %0d full %0d, ",
                           want.count, want.blacklisted, want.table_full,
                           "got count %0d blacklisted %0d full %0d",
                           seen.count, seen.blacklisted, seen.table_full);
               end
               verdict_errors++;
            end
         end
      end
   end

   initial begin : stimulus
      logic [ADDR_W-1:0] addr_pool [POOL_N];
      logic [ADDR_W-1:0] focus;
      logic [ADDR_W-1:0] addr;
      logic [TIME_W-1:0] now_s;
      logic [1:0]        mode;
      int                burst_left;
      int                clear_pct;
      int                r;

      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         ban_valid[i] = 1'b0;
         ban_addr[i]  = '0;
         ban_count[i] = '0;
         ban_last[i]  = '0;
      end
      // The pool holds the addresses that bursts keep returning to, with both
      // address extremes among them.
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      for (int i = 2; i < POOL_N; i++) addr_pool[i] = $urandom;
      focus      = '0;
      now_s      = 32'd1000;
      burst_left = 0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         // Registers only change once every beat of the previous phase has
         // come back, so the block is idle when they are written.
         if (phase > 0) begin
            while (pending_verdicts.size() != 0) @(posedge clock);
            case (phase)
               1: begin
                  write_register(fabt_pkg::CSR_WINDOW, 20'd0);
                  write_register(fabt_pkg::CSR_THRESHOLD, 20'd1);
                  write_register(fabt_pkg::CSR_DURATION, 20'd0);
               end
               2: begin
                  write_register(fabt_pkg::CSR_WINDOW, 20'hFFFFF);
                  write_register(fabt_pkg::CSR_THRESHOLD, 20'h0FFFF);
                  write_register(fabt_pkg::CSR_DURATION, 20'hFFFFF);
                  write_register(CSR_NONE, 20'hABCDE);
               end
               3: begin
                  // With a threshold of zero, a check blacklists every stored address still within the duration.
                  write_register(fabt_pkg::CSR_WINDOW, 20'd200);
                  write_register(fabt_pkg::CSR_THRESHOLD, 20'd0);
                  write_register(fabt_pkg::CSR_DURATION, 20'd50);
               end
               default: begin
                  write_register(fabt_pkg::CSR_WINDOW, SPAN_W'($urandom_range(500, 1)));
                  write_register(fabt_pkg::CSR_THRESHOLD, SPAN_W'($urandom_range(6, 2)));
                  write_register(fabt_pkg::CSR_DURATION, SPAN_W'($urandom_range(2000, 100)));
               end
            endcase
            csr_valid <= 1'b0;
         end

         case (phase % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 47; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 47; end
            default: begin send_idle_pct = 22; rsp_stall_pct = 22; end
         endcase
         // Fewer clears in the middle phases let the table fill up.
         clear_pct = (phase == 1 || phase == 2) ? 2 : 8;

         if (phase == 0) begin
            for (int d = 0; d < DIRECTED_N; d++) begin
               send_request(directed_rows[d].mode, directed_rows[d].addr,
                            directed_rows[d].now_s, directed_rows[d].typed,
                            directed_rows[d].verdict);
            end
         end

         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (phase == 2 && n < FLOOD_ITEMS) begin
               // A flood of fresh addresses drives the table to full, after
               // which new addresses must be turned away.
               now_s = now_s + 32'd1;
               send_request(fabt_pkg::MODE_RECORD, $urandom, now_s, 1'b0, '0);
            end else begin
               // Most beats come in bursts on one address with small time
               // steps, so that counts climb, reach the threshold and expire.
               if (burst_left == 0) begin
                  burst_left = $urandom_range(12, 1);
                  focus      = addr_pool[$urandom_range(POOL_N - 1)];
                  r          = $urandom_range(99);
                  if (r < 40) begin
                     now_s = now_s + $urandom_range(int'(cur_window) + 1);
                  end else if (r < 65) begin
                     now_s = now_s + $urandom_range(2 * int'(cur_window) +
                                                    int'(cur_duration) + 2);
                  end else if (r < 78) begin
                     now_s = now_s - $urandom_range(200);
                  end else if (r < 90) begin
                     now_s = $urandom;
                  end else begin
                     now_s = 32'hFFFF_FFFF - $urandom_range(300);
                  end
               end
               burst_left--;
               r = $urandom_range(99);
               if (r < 3) begin
                  mode = MODE_UNUSED;
               end else if (r < 3 + clear_pct) begin
                  mode = fabt_pkg::MODE_CLEAR;
               end else if (r < 33) begin
                  mode = fabt_pkg::MODE_CHECK;
               end else begin
                  mode = fabt_pkg::MODE_RECORD;
               end
               addr = ($urandom_range(9) == 0) ? $urandom : focus;
               if ($urandom_range(9) == 0) begin
                  now_s = now_s + $urandom_range(2 * int'(cur_window) +
                                                 int'(cur_duration) + 2);
               end else begin
                  now_s = now_s + $urandom_range(int'(cur_window) / 3 + 1);
               end
               send_request(mode, addr, now_s, 1'b0, '0);
            end
         end
         req_tvalid <= 1'b0;
      end

      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (verdict_errors == 0) begin
         $display("tb_failed_attempt_blacklist_table_unit OK");
      end else begin
         $display("tb_failed_attempt_blacklist_table_unit NOT OK");
      end
      $finish;
   end

endmodule
